// File: hdl/bqfi_pkg.sv
`default_nettype none
package bqfi_pkg;
  localparam int CAPACITY_DEF   = 64;
  localparam int COORD_BITS_DEF = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_SETBOX = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_MATCH     = 3'd3,
    ST_NO_MATCH  = 3'd4
  } status_t;

  // one queued command between front and back
  typedef struct packed {
    opcode_t     opcode;
    logic [15:0] entry_id;
    logic [15:0] x_min;
    logic [15:0] y_min;
    logic [15:0] x_max;
    logic [15:0] y_max;
  } cmd_t;
endpackage
`default_nettype wire

// File: hdl/bqfi_if.sv
`default_nettype none
interface bqfi_in_if;
  import bqfi_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] entry_id;
  logic signed [15:0] box_x_min;
  logic signed [15:0] box_y_min;
  logic signed [15:0] box_x_max;
  logic signed [15:0] box_y_max;
  modport source (output valid, opcode, entry_id, box_x_min, box_y_min, box_x_max,
                  box_y_max, input ready);
  modport sink (input valid, opcode, entry_id, box_x_min, box_y_min, box_x_max,
                box_y_max, output ready);
endinterface

interface bqfi_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] match_id;
  logic        last_result;
  modport source (output valid, status, match_id, last_result, input ready);
  modport sink (input valid, status, match_id, last_result, output ready);
endinterface
`default_nettype wire

// File: hdl/bqfi_ram.sv
`default_nettype none
module bqfi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hdl/bqfi_front.sv
`default_nettype none
// Front: registers commands from the input channel into a two-entry queue.
module bqfi_front import bqfi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  bqfi_in_if.sink   in_ch,
  output logic      q_valid,
  output cmd_t      q_cmd,
  input  wire logic q_pop
);
  cmd_t       buf_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  cmd_t       c;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push    = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = buf_r[rp_r];

  always_comb begin
    c.opcode   = opcode_t'(in_ch.opcode);
    c.entry_id = in_ch.entry_id;
    c.x_min    = in_ch.box_x_min;
    c.y_min    = in_ch.box_y_min;
    c.x_max    = in_ch.box_x_max;
    c.y_max    = in_ch.box_y_max;
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= c;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push) else $error("queue overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
endmodule
`default_nettype wire

// File: hdl/bqfi_back.sv
`default_nettype none
// Back: scans the table in the RAMs one entry per cycle unless a query hit waits.
module bqfi_back import bqfi_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic key_mode,
  input  wire logic q_valid,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  bqfi_out_if.source out_ch
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int BW = 4 * COORD_BITS;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_EVAL  = 6'b000100,
    S_MOVE  = 6'b001000,
    S_MOVE2 = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  cmd_t   cmd_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;      // address issued to RAM
  logic [AW-1:0] hit_r, hit_nxt;
  logic          any_r, any_nxt;

  // output register plus the most recent match, held until the next hit or scan end
  logic          ov_r, ov_nxt;
  logic [2:0]    ost_r, ost_nxt;
  logic [15:0]   oid_r, oid_nxt;
  logic          olast_r, olast_nxt;
  logic          pv_r, pv_nxt;
  logic [15:0]   pid_r, pid_nxt;

  logic          rd_v_r;              // RAM data valid for entry rdi_r
  logic [AW-1:0] rdi_r;

  logic          id_we, bx_we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   id_wd, id_rd;
  logic [BW-1:0] bx_wd, bx_rd;

  bqfi_ram #(.WIDTH(16), .DEPTH(CAPACITY)) u_ids (
    .clk, .we(id_we), .waddr, .wdata(id_wd), .raddr, .rdata(id_rd));
  bqfi_ram #(.WIDTH(BW), .DEPTH(CAPACITY)) u_boxes (
    .clk, .we(bx_we), .waddr, .wdata(bx_wd), .raddr, .rdata(bx_rd));

  logic signed [COORD_BITS-1:0] qx0, qy0, qx1, qy1, ex0, ey0, ex1, ey1;
  logic match;
  assign qx0 = cmd_r.x_min[COORD_BITS-1:0];
  assign qy0 = cmd_r.y_min[COORD_BITS-1:0];
  assign qx1 = cmd_r.x_max[COORD_BITS-1:0];
  assign qy1 = cmd_r.y_max[COORD_BITS-1:0];
  assign ex0 = bx_rd[BW-1 -: COORD_BITS];
  assign ey0 = bx_rd[3*COORD_BITS-1 -: COORD_BITS];
  assign ex1 = bx_rd[2*COORD_BITS-1 -: COORD_BITS];
  assign ey1 = bx_rd[COORD_BITS-1:0];

  always_comb begin
    if (!key_mode)
      match = ex0 >= qx0 && ex0 <= qx1 && ey0 >= qy0 && ey0 <= qy1;
    else
      match = qx0 <= ex1 && ex0 <= qx1 && qy0 <= ey1 && ey0 <= qy1;
  end

  logic out_free;
  assign out_free = !ov_r || out_ch.ready;
  assign out_ch.valid       = ov_r;
  assign out_ch.status      = ost_r;
  assign out_ch.match_id    = oid_r;
  assign out_ch.last_result = olast_r;

  logic rd_issue;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    hit_nxt   = hit_r;
    any_nxt   = any_r;
    ov_nxt    = ov_r && !out_ch.ready;
    ost_nxt   = ost_r;
    oid_nxt   = oid_r;
    olast_nxt = olast_r;
    pv_nxt    = pv_r;
    pid_nxt   = pid_r;
    q_pop     = 1'b0;
    id_we     = 1'b0;
    bx_we     = 1'b0;
    waddr     = count_r[AW-1:0];
    id_wd     = cmd_r.entry_id;
    bx_wd     = {qx0, qy0, qx1, qy1};
    raddr     = idx_r[AW-1:0];
    rd_issue  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          idx_nxt = '0;
          any_nxt = 1'b0;
          state_nxt = (q_cmd.opcode == OP_INSERT) ? S_EMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx_r < count_r) begin
          rd_issue = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
        if (rd_v_r) begin
          if (cmd_r.opcode == OP_QUERY) begin
            if (match && pv_r && !out_free) begin
              // no room for this hit yet: read the same entry again
              raddr = rdi_r;
              rd_issue = 1'b1;
              idx_nxt = idx_r;
            end else if (match) begin
              if (pv_r) begin
                ov_nxt = 1'b1; ost_nxt = ST_MATCH; oid_nxt = pid_r; olast_nxt = 1'b0;
              end
              any_nxt = 1'b1;
              pv_nxt = 1'b1; pid_nxt = id_rd;
            end
          end else if (id_rd == cmd_r.entry_id) begin
            any_nxt = 1'b1;
            hit_nxt = rdi_r;
            rd_issue = 1'b0;
            idx_nxt = idx_r;
            state_nxt = S_EVAL;
          end
        end
        if (!rd_issue && !rd_v_r && state_nxt == S_SCAN) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (cmd_r.opcode == OP_REMOVE && any_r) begin
          count_nxt = count_r - 1'b1;
          raddr = count_nxt[AW-1:0];
          state_nxt = S_MOVE;
        end else begin
          if (cmd_r.opcode == OP_SETBOX && any_r) begin
            bx_we = 1'b1; waddr = hit_r;
          end
          state_nxt = S_EMIT;
        end
      end
      S_MOVE: begin
        raddr = count_r[AW-1:0];
        state_nxt = S_MOVE2;
      end
      S_MOVE2: begin
        id_we = 1'b1; bx_we = 1'b1; waddr = hit_r;
        id_wd = id_rd; bx_wd = bx_rd;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          ov_nxt = 1'b1; oid_nxt = 16'd0; olast_nxt = 1'b1;
          state_nxt = S_IDLE;
          case (cmd_r.opcode)
            OP_INSERT: begin
              if (count_r >= CW'(CAPACITY)) ost_nxt = ST_FULL;
              else begin
                ost_nxt = ST_DONE;
                id_we = 1'b1; bx_we = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_QUERY: begin
              // the held match is the final one
              if (any_r) begin
                ost_nxt = ST_MATCH; oid_nxt = pid_r; pv_nxt = 1'b0;
              end else ost_nxt = ST_NO_MATCH;
            end
            default: ost_nxt = any_r ? ST_DONE : ST_NOT_FOUND;
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && q_pop) cmd_r <= q_cmd;
    hit_r <= hit_nxt; idx_r <= idx_nxt; any_r <= any_nxt;
    ost_r <= ost_nxt; oid_r <= oid_nxt; olast_r <= olast_nxt; pid_r <= pid_nxt;
    rdi_r <= raddr;
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= '0; ov_r <= 1'b0; pv_r <= 1'b0; rd_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt;
      ov_r <= ov_nxt; pv_r <= pv_nxt; rd_v_r <= rd_issue;
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY)) else $error("entry count beyond capacity");
  a_pend_one: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r && !out_free |=> pv_r) else $error("pending match lost");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pv_r) else $error("pending match left at idle");
endmodule
`default_nettype wire

// File: hdl/box_query_flat_index.sv
// Flat bounding-box table of up to CAPACITY entries. Insert needs no scan;
// remove, set box and query scan the table through a read address shared by both
// RAMs, one entry per cycle unless a query hit waits on the result channel.
// Remove and set box stop at the first hit. Query emits one match transfer per hit;
// each match is held back until the next hit or the end of the scan so the final
// one carries its last flag, and a hit that finds one held and the result path
// full is read again. A two-deep command queue lets the input side run ahead.
`default_nettype none
module box_query_flat_index import bqfi_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  bqfi_in_if.sink   in_ch,
  bqfi_out_if.source out_ch
);
  logic key_mode_r;
  logic q_valid, q_pop;
  cmd_t q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) key_mode_r <= 1'b0;
    else if (cfg_we) key_mode_r <= cfg_wdata;
  end

  bqfi_front u_front (.clk, .rst_n, .in_ch, .q_valid, .q_cmd, .q_pop);

  bqfi_back #(.CAPACITY(CAPACITY), .COORD_BITS(COORD_BITS)) u_back (
    .clk, .rst_n, .key_mode(key_mode_r), .q_valid, .q_cmd, .q_pop, .out_ch);
endmodule
`default_nettype wire
